// ===== src/uart_rfg_pkg.sv =====
// Shared types, codes and reset constants for the UART receive ring frame gatherer.
package uart_rfg_pkg;

    localparam int RING_DEPTH_DEF = 32;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int LEN_W   = 16;
    localparam int CAUSE_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] TERM_RST     = 8'd0;
    localparam logic [BYTE_W-1:0] MIN_LEN_RST  = 8'd6;
    localparam logic [BYTE_W-1:0] IDLE_LIM_RST = 8'd20;

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE  = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_START = 2'd2,
        KIND_FLUSH = 2'd3
    } kind_t;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_TERM   = 2'd0,
        CAUSE_IDLE   = 2'd1,
        CAUSE_BUDGET = 2'd2
    } cause_t;

    localparam logic [CFG_IDX_W-1:0] CFG_TERMINATOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_CALC  = 3'b100
    } state_t;

endpackage

// ===== src/uart_rx_ring_frame_gatherer_core.sv =====
// UART receive byte ring with a read session framer on idle gap, terminator and budget.
//
//   channel   direction   handshake            payload
//   s_        in          s_valid / s_ready    s_kind, s_rx_data, s_max_len, s_time_budget
//   m_        out         m_valid / m_ready    m_data .. m_byte_count, one word per result
//   cfg_      in          cfg_we               cfg_index, cfg_wdata
//
// A word that causes no result is handled in the idle state; a wait tick that ends the
// session issues its result from the calc state. Each byte drained from the ring
// goes through the fetch state (ring memory read) and the calc state (result register).
// Reset is synchronous and needs no clearing pass. s_ready is low while a word is
// at work, and a stalled m_ready holds the block in its result stage.
module uart_rx_ring_frame_gatherer_core #(
    parameter int RING_DEPTH = uart_rfg_pkg::RING_DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [uart_rfg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [uart_rfg_pkg::BYTE_W-1:0]      cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [uart_rfg_pkg::KIND_W-1:0]      s_kind,
    input  logic [uart_rfg_pkg::BYTE_W-1:0]      s_rx_data,
    input  logic [uart_rfg_pkg::LEN_W-1:0]       s_max_len,
    input  logic [uart_rfg_pkg::LEN_W-1:0]       s_time_budget,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [uart_rfg_pkg::BYTE_W-1:0]      m_data,
    output logic                                 m_has_data,
    output logic                                 m_stored,
    output logic [uart_rfg_pkg::LEN_W-1:0]       m_position,
    output logic                                 m_done_res,
    output logic [uart_rfg_pkg::CAUSE_W-1:0]     m_end_cause,
    output logic [uart_rfg_pkg::LEN_W-1:0]       m_byte_count
);
    import uart_rfg_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              active_reg, active_next;
    logic [LEN_W-1:0]  stored_reg, stored_next;
    logic [LEN_W-1:0]  budget_reg, budget_next;
    logic [BYTE_W-1:0] idle_reg, idle_next;
    logic [LEN_W-1:0]  limit_reg, limit_next;
    logic [BYTE_W-1:0] term_reg, min_len_reg, idle_lim_reg;
    logic              tick_pend_reg, tick_pend_next;
    cause_t            tick_cause_reg, tick_cause_next;

    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_data_reg, m_data_next;
    logic              m_has_data_reg, m_has_data_next;
    logic              m_stored_reg, m_stored_next;
    logic [LEN_W-1:0]  m_position_reg, m_position_next;
    logic              m_done_reg, m_done_next;
    cause_t            m_cause_reg, m_cause_next;
    logic [LEN_W-1:0]  m_count_reg, m_count_next;

    logic              accept;
    logic              push;
    logic              out_free;
    logic [IDX_W-1:0]  wr_inc, rd_inc;
    logic [BYTE_W:0]   idle_inc;
    logic [LEN_W-1:0]  budget_dec;
    logic              fits;
    logic [LEN_W-1:0]  stored_after;
    logic              term_hit;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign wr_inc   = (wr_idx_reg == IDX_LAST) ? '0 : wr_idx_reg + 1'b1;
    assign rd_inc   = (rd_idx_reg == IDX_LAST) ? '0 : rd_idx_reg + 1'b1;
    assign push     = accept && (kind_t'(s_kind) == KIND_BYTE) && (wr_inc != rd_idx_reg);

    assign idle_inc     = {1'b0, idle_reg} + 1'b1;
    assign budget_dec   = (budget_reg != '0) ? budget_reg - 1'b1 : '0;
    assign fits         = stored_reg < limit_reg;
    assign stored_after = fits ? stored_reg + 1'b1 : stored_reg;
    assign term_hit     = (rd_data_reg == term_reg)
                          && (stored_after >= {{(LEN_W-BYTE_W){1'b0}}, min_len_reg});

    always_ff @(posedge aclk) begin
        if (push) begin
            ring_mem[wr_idx_reg] <= s_rx_data;
        end
        rd_data_reg <= ring_mem[rd_idx_reg];
    end

    always_comb begin
        state_next      = state_reg;
        wr_idx_next     = wr_idx_reg;
        rd_idx_next     = rd_idx_reg;
        active_next     = active_reg;
        stored_next     = stored_reg;
        budget_next     = budget_reg;
        idle_next       = idle_reg;
        limit_next      = limit_reg;
        tick_pend_next  = tick_pend_reg;
        tick_cause_next = tick_cause_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        m_has_data_next = m_has_data_reg;
        m_stored_next   = m_stored_reg;
        m_position_next = m_position_reg;
        m_done_next     = m_done_reg;
        m_cause_next    = m_cause_reg;
        m_count_next    = m_count_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (kind_t'(s_kind))
                        KIND_BYTE: begin
                            if (push) begin
                                wr_idx_next = wr_inc;
                            end
                            if (active_reg && (wr_idx_next != rd_idx_reg)) begin
                                state_next = ST_FETCH;
                            end
                        end
                        KIND_TICK: begin
                            if (active_reg) begin
                                if ((stored_reg != '0)
                                    && (idle_inc >= {1'b0, idle_lim_reg})) begin
                                    idle_next       = idle_inc[BYTE_W-1:0];
                                    active_next     = 1'b0;
                                    tick_pend_next  = 1'b1;
                                    tick_cause_next = CAUSE_IDLE;
                                    state_next      = ST_CALC;
                                end else begin
                                    if (stored_reg != '0) begin
                                        idle_next = idle_inc[BYTE_W-1:0];
                                    end
                                    budget_next = budget_dec;
                                    if (budget_dec == '0) begin
                                        active_next     = 1'b0;
                                        tick_pend_next  = 1'b1;
                                        tick_cause_next = CAUSE_BUDGET;
                                        state_next      = ST_CALC;
                                    end
                                end
                            end
                        end
                        KIND_START: begin
                            active_next = 1'b1;
                            stored_next = '0;
                            idle_next   = '0;
                            limit_next  = s_max_len;
                            budget_next = (s_time_budget == '0) ? LEN_W'(1) : s_time_budget;
                            if (wr_idx_reg != rd_idx_reg) begin
                                state_next = ST_FETCH;
                            end
                        end
                        KIND_FLUSH: begin
                            rd_idx_next = wr_idx_reg;
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                state_next = ST_CALC;
            end
            ST_CALC: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_count_next = stored_reg;
                    if (tick_pend_reg) begin
                        tick_pend_next  = 1'b0;
                        m_data_next     = '0;
                        m_has_data_next = 1'b0;
                        m_stored_next   = 1'b0;
                        m_position_next = '0;
                        m_done_next     = 1'b1;
                        m_cause_next    = tick_cause_reg;
                        state_next      = ST_IDLE;
                    end else begin
                        rd_idx_next     = rd_inc;
                        stored_next     = stored_after;
                        idle_next       = '0;
                        active_next     = !term_hit;
                        m_data_next     = rd_data_reg;
                        m_has_data_next = 1'b1;
                        m_stored_next   = fits;
                        m_position_next = fits ? stored_reg : '0;
                        m_done_next     = term_hit;
                        m_cause_next    = CAUSE_TERM;
                        m_count_next    = stored_after;
                        if (!term_hit && (rd_inc != wr_idx_reg)) begin
                            state_next = ST_FETCH;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            active_reg    <= 1'b0;
            stored_reg    <= '0;
            budget_reg    <= '0;
            idle_reg      <= '0;
            limit_reg     <= '0;
            tick_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            term_reg      <= TERM_RST;
            min_len_reg   <= MIN_LEN_RST;
            idle_lim_reg  <= IDLE_LIM_RST;
        end else begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            active_reg    <= active_next;
            stored_reg    <= stored_next;
            budget_reg    <= budget_next;
            idle_reg      <= idle_next;
            limit_reg     <= limit_next;
            tick_pend_reg <= tick_pend_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_TERMINATOR: term_reg     <= cfg_wdata;
                    CFG_MIN_LEN:    min_len_reg  <= cfg_wdata;
                    CFG_IDLE_LIMIT: idle_lim_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        tick_cause_reg <= tick_cause_next;
        m_data_reg     <= m_data_next;
        m_has_data_reg <= m_has_data_next;
        m_stored_reg   <= m_stored_next;
        m_position_reg <= m_position_next;
        m_done_reg     <= m_done_next;
        m_cause_reg    <= m_cause_next;
        m_count_reg    <= m_count_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;
    assign m_has_data   = m_has_data_reg;
    assign m_stored     = m_stored_reg;
    assign m_position   = m_position_reg;
    assign m_done_res   = m_done_reg;
    assign m_end_cause  = m_cause_reg;
    assign m_byte_count = m_count_reg;

    // The fetch state is never entered while the ring is empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH) |-> (rd_idx_reg != wr_idx_reg))
        else $error("ring read while empty");

    // A byte is only drained inside an active session.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC && !tick_pend_reg) |-> active_reg)
        else $error("drain outside a session");

    // A result without a byte always closes the session.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_has_data) |-> (m_done_res && !m_stored))
        else $error("tick word without session end");

    // A stored byte goes to the slot just below the updated count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_stored) |-> (m_byte_count == m_position + 1'b1))
        else $error("stored position does not match count");

endmodule
